@@ hdl/gcd_pkg.sv @@
`default_nettype none

package gcd_pkg;

  // Default build settings.
  localparam int CORDIC_STAGES_DEF   = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 30;

  // Field and bus widths.
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int DIST_W     = 31;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 32;

  // Degrees times 1e7 to radians, as pi / 1.8e9 scaled by 2^56.
  localparam logic [26:0] RAD_PER_DEG7_Q56 = 27'd125764227;

  // Constants held with 40 fraction bits.
  localparam logic [63:0] PI_Q40      = 64'd3454217652358;
  localparam logic [63:0] HALF_PI_Q40 = 64'd1727108826179;
  localparam logic [63:0] GAIN_Q40    = 64'd667681663043;

  localparam logic [63:0] ARCTAN_Q40 [14] = '{
    64'd863554413089, 64'd509785937287, 64'd269356888665, 64'd136729762476,
    64'd68630207382,  64'd34348560106,  64'd17178471287,  64'd8589759836,
    64'd4294945451,   64'd2147480917,   64'd1073741483,   64'd536870869,
    64'd268435451,    64'd134217727
  };

  // Twice the earth radius in centimeters, and the distance ceiling.
  localparam logic signed [31:0] TWO_RADIUS_CM = 32'sd1274200000;
  localparam logic [33:0]        DIST_MAX      = 34'd2001508700;

  // Round a value with 40 fraction bits to f fraction bits, half up.
  function automatic logic [63:0] from_q40(input logic [63:0] v, input int f);
    int s;
    s = 40 - f;
    if (s == 0) begin
      return v;
    end
    return (v >> s) + ((v >> (s - 1)) & 64'd1);
  endfunction

  // Rotation angle of CORDIC step i with f fraction bits.
  function automatic logic [63:0] arctan_q(input int i, input int f);
    logic [63:0] v;
    if (i < 14) begin
      v = ARCTAN_Q40[i];
    end else begin
      v = 64'd1 << (40 - i);
    end
    return from_q40(v, f);
  endfunction

endpackage

`default_nettype wire

@@ hdl/gcd_mul.sv @@
`default_nettype none

// Pipelined signed multiply, rounded half up on the magnitude and shifted.
// Stage 1 takes magnitudes, stage 2 forms four half-width partial products,
// stage 3 sums, rounds and restores the sign.
module gcd_mul import gcd_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int SH = 30,
  parameter int OW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic                      out_vld,
  output logic signed [OW-1:0]      p
);

  localparam int LA = AW / 2;
  localparam int HA = AW - LA;
  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW + 1;

  logic [AW-1:0]    ma_r;
  logic [BW-1:0]    mb_r;
  logic             neg1_r, neg2_r;
  logic [HA+HB-1:0] phh_r;
  logic [HA+LB-1:0] phl_r;
  logic [LA+HB-1:0] plh_r;
  logic [LA+LB-1:0] pll_r;
  logic [2:0]       vld_r;
  logic [PW-1:0]    full;
  logic [PW-1:0]    mag;
  logic signed [OW-1:0] p_r;

  // Valid bits follow the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // Stage 1: magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= a[AW-1] ? AW'(-a) : AW'(a);
      mb_r   <= b[BW-1] ? BW'(-b) : BW'(b);
      neg1_r <= a[AW-1] ^ b[BW-1];
    end
  end

  // Stage 2: partial products of the halves.
  always_ff @(posedge clk) begin
    if (en) begin
      phh_r  <= (HA+HB)'(ma_r[AW-1:LA]) * (HA+HB)'(mb_r[BW-1:LB]);
      phl_r  <= (HA+LB)'(ma_r[AW-1:LA]) * (HA+LB)'(mb_r[LB-1:0]);
      plh_r  <= (LA+HB)'(ma_r[LA-1:0]) * (LA+HB)'(mb_r[BW-1:LB]);
      pll_r  <= (LA+LB)'(ma_r[LA-1:0]) * (LA+LB)'(mb_r[LB-1:0]);
      neg2_r <= neg1_r;
    end
  end

  // Stage 3: sum, round half up, shift and restore the sign.
  always_comb begin
    full = (PW'(phh_r) << (LA + LB)) + (PW'(phl_r) << LA) + (PW'(plh_r) << LB)
         + PW'(pll_r) + (PW'(1) << (SH - 1));
    mag  = full >> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg2_r ? OW'(-mag) : OW'(mag);
    end
  end

  assign p       = p_r;
  assign out_vld = vld_r[2];

endmodule

`default_nettype wire

@@ hdl/gcd_cordic.sv @@
`default_nettype none

// Unrolled CORDIC, one register stage per iteration. VECTOR selects
// vectoring mode (drive y to zero) instead of rotation mode (drive z to zero).
module gcd_cordic import gcd_pkg::*; #(
  parameter int STAGES = 24,
  parameter int F      = 30,
  parameter int XW     = 33,
  parameter int ZW     = 35,
  parameter int SBW    = 1,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic signed [XW-1:0]  x0,
  input  wire logic signed [XW-1:0]  y0,
  input  wire logic signed [ZW-1:0]  z0,
  input  wire logic [SBW-1:0]        sb0,
  output logic                       out_vld,
  output logic signed [XW-1:0]       x,
  output logic signed [XW-1:0]       y,
  output logic signed [ZW-1:0]       z,
  output logic [SBW-1:0]             sb
);

  logic signed [XW-1:0] x_r  [STAGES];
  logic signed [XW-1:0] y_r  [STAGES];
  logic signed [ZW-1:0] z_r  [STAGES];
  logic [SBW-1:0]       sb_r [STAGES];
  logic [STAGES-1:0]    vld_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(arctan_q(i, F));

    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in;
    logic [SBW-1:0]       sb_in;
    logic                 vld_in;
    logic                 step_neg;

    if (i == 0) begin : g_first
      assign x_in   = x0;
      assign y_in   = y0;
      assign z_in   = z0;
      assign sb_in  = sb0;
      assign vld_in = in_vld;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign sb_in  = sb_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    // Arithmetic shifts round toward minus infinity.
    assign dx       = y_in >>> i;
    assign dy       = x_in >>> i;
    assign step_neg = VECTOR ? !y_in[XW-1] : z_in[ZW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    // One micro-rotation.
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i] <= sb_in;
        if (!step_neg) begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - AT;
        end else begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + AT;
        end
      end
    end
  end

  assign x       = x_r[STAGES-1];
  assign y       = y_r[STAGES-1];
  assign z       = z_r[STAGES-1];
  assign sb      = sb_r[STAGES-1];
  assign out_vld = vld_r[STAGES-1];

endmodule

`default_nettype wire

@@ hdl/gcd_sqrt.sv @@
`default_nettype none

// Pipelined digit-by-digit square root of v / 2^F, result with F fraction
// bits, rounded to nearest. One root bit per stage plus a rounding stage.
module gcd_sqrt import gcd_pkg::*; #(
  parameter int F = 30
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       in_vld,
  input  wire logic [F:0] v,
  output logic            out_vld,
  output logic [F:0]      root
);

  localparam int NS = F + 1;
  localparam int NW = 2 * F + 2;
  localparam int RW = F + 4;

  logic [F:0]    root_r [NS];
  logic [RW-1:0] rem_r  [NS];
  logic [NW-1:0] n_r    [NS];
  logic [NS-1:0] vld_r;
  logic [F:0]    res_r;
  logic          res_vld_r;

  for (genvar j = 0; j < NS; j++) begin : g_digit
    logic [F:0]    root_in;
    logic [RW-1:0] rem_in, rem_sh, trial;
    logic [NW-1:0] n_in;
    logic          vld_in;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign n_in    = {1'b0, v, {F{1'b0}}};
      assign vld_in  = in_vld;
    end else begin : g_next
      assign root_in = root_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign n_in    = n_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // Bring down the next bit pair and try the new root bit.
    assign rem_sh = {rem_in[RW-3:0], n_in[NW-1 -: 2]};
    assign trial  = RW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j] <= n_in << 2;
        if (rem_sh >= trial) begin
          rem_r[j]  <= rem_sh - trial;
          root_r[j] <= {root_in[F-1:0], 1'b1};
        end else begin
          rem_r[j]  <= rem_sh;
          root_r[j] <= {root_in[F-1:0], 1'b0};
        end
      end
    end
  end

  // Round to nearest from the final remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (en) begin
      res_vld_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= (rem_r[NS-1] > RW'(root_r[NS-1])) ? root_r[NS-1] + 1'b1 : root_r[NS-1];
    end
  end

  assign root    = res_r;
  assign out_vld = res_vld_r;

endmodule

`default_nettype wire

@@ hdl/great_circle_distance_core.sv @@
// Haversine great-circle distance between two GPS points.
// Input channel in_*: one request per pair of points, latitude and longitude
// in signed degrees times 1e7. Result channel out_*: the distance in
// centimeters on a sphere of radius 6371 km, saturated at 2001508700.
// The datapath is a single pipeline: four sine/cosine CORDIC lanes, pipelined
// multipliers, two bit-per-stage square roots and an arctangent CORDIC, so a
// new request is taken every cycle and throughput is one result per cycle,
// except while the receiver stalls the output as described below.
// The last stage is the output register. When the receiver holds out_tready
// low while a result is shown, the whole pipeline freezes and in_tready
// drops; nothing is lost or repeated, and flow resumes once out_tready rises.
// Reset clears all valid bits; the block keeps no state between requests.
`default_nettype none

module great_circle_distance_core import gcd_pkg::*; #(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // lat_first[30:0], lon_first[62:31], lat_second[93:63], lon_second[125:94]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // distance_cm[30:0]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 5;
  localparam int XW = F + 3;
  localparam int HW = F + 1;
  localparam int DW = 34;

  localparam logic signed [AW-1:0] PI_A    = AW'(from_q40(PI_Q40, F));
  localparam logic signed [AW-1:0] HP_A    = AW'(from_q40(HALF_PI_Q40, F));
  localparam logic signed [XW-1:0] GAIN_X  = XW'(from_q40(GAIN_Q40, F));
  localparam logic [HW-1:0]        ONE_H   = HW'(1) << F;
  localparam logic [HW-1:0]        HP_H    = HW'(from_q40(HALF_PI_Q40, F));

  logic en;

  // The pipeline advances unless a result is held by the receiver.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: unpack, form the latitude and longitude differences.
  logic signed [32:0] deg_r [4];
  logic               s1_vld_r;
  logic signed [32:0] lat1_x, lat2_x, lon1_x, lon2_x;

  assign lat1_x = 33'(signed'(in_tdata[30:0]));
  assign lon1_x = 33'(signed'(in_tdata[62:31]));
  assign lat2_x = 33'(signed'(in_tdata[93:63]));
  assign lon2_x = 33'(signed'(in_tdata[125:94]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r[0] <= lat1_x;
      deg_r[1] <= lat2_x;
      deg_r[2] <= lat2_x - lat1_x;
      deg_r[3] <= lon2_x - lon1_x;
    end
  end

  // Stages 2 to 4 per lane: scale to radians, round, fold into a right angle.
  logic [59:0]          prod_r [4];
  logic                 sgn_r  [4];
  logic signed [AW-1:0] ang_r  [4];
  logic signed [AW-1:0] za_r   [4];
  logic                 flip_r [4];
  logic                 s2_vld_r, s3_vld_r, s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_angle
    // Half angles for the difference lanes.
    localparam int SH = 56 - F + ((i >= 2) ? 1 : 0);

    logic [32:0] mag;
    logic [59:0] rnd;

    assign mag = deg_r[i][32] ? 33'(-deg_r[i]) : 33'(deg_r[i]);
    assign rnd = (prod_r[i] >> SH) + 60'(prod_r[i][SH-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[i] <= {27'd0, mag} * {33'd0, RAD_PER_DEG7_Q56};
        sgn_r[i]  <= deg_r[i][32];
        ang_r[i]  <= sgn_r[i] ? AW'(-rnd) : AW'(rnd);
        if (ang_r[i] > HP_A) begin
          za_r[i]   <= ang_r[i] - PI_A;
          flip_r[i] <= 1'b1;
        end else if (ang_r[i] < -HP_A) begin
          za_r[i]   <= ang_r[i] + PI_A;
          flip_r[i] <= 1'b1;
        end else begin
          za_r[i]   <= ang_r[i];
          flip_r[i] <= 1'b0;
        end
      end
    end
  end

  // Sine and cosine, one rotation CORDIC per lane.
  logic signed [XW-1:0] rx [4];
  logic signed [XW-1:0] ry [4];
  logic                 rflip [4];
  logic                 rot_vld;

  for (genvar i = 0; i < 4; i++) begin : g_rot
    if (i == 0) begin : g_vld
      gcd_cordic #(
        .STAGES(CORDIC_STAGES), .F(F), .XW(XW), .ZW(AW), .SBW(1), .VECTOR(1'b0)
      ) u_rot (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s4_vld_r),
        .x0(GAIN_X), .y0('0), .z0(za_r[i]), .sb0(flip_r[i]),
        .out_vld(rot_vld), .x(rx[i]), .y(ry[i]), .z(), .sb(rflip[i])
      );
    end else begin : g_novld
      gcd_cordic #(
        .STAGES(CORDIC_STAGES), .F(F), .XW(XW), .ZW(AW), .SBW(1), .VECTOR(1'b0)
      ) u_rot (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s4_vld_r),
        .x0(GAIN_X), .y0('0), .z0(za_r[i]), .sb0(flip_r[i]),
        .out_vld(), .x(rx[i]), .y(ry[i]), .z(), .sb(rflip[i])
      );
    end
  end

  // Undo the fold by negating sine and cosine.
  logic signed [XW-1:0] c1_r, c2_r, slat_r, slon_r;
  logic                 trig_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_vld_r <= 1'b0;
    end else if (en) begin
      trig_vld_r <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= rflip[0] ? -rx[0] : rx[0];
      c2_r   <= rflip[1] ? -rx[1] : rx[1];
      slat_r <= rflip[2] ? -ry[2] : ry[2];
      slon_r <= rflip[3] ? -ry[3] : ry[3];
    end
  end

  // Squares of the half-angle sines and the cosine product.
  logic signed [XW-1:0] slat2, slon2, cc;
  logic                 m1_vld;

  gcd_mul #(.AW(XW), .BW(XW), .SH(F), .OW(XW)) u_mul_slat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(trig_vld_r),
    .a(slat_r), .b(slat_r), .out_vld(m1_vld), .p(slat2)
  );

  gcd_mul #(.AW(XW), .BW(XW), .SH(F), .OW(XW)) u_mul_slon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(trig_vld_r),
    .a(slon_r), .b(slon_r), .out_vld(), .p(slon2)
  );

  gcd_mul #(.AW(XW), .BW(XW), .SH(F), .OW(XW)) u_mul_cc (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(trig_vld_r),
    .a(c1_r), .b(c2_r), .out_vld(), .p(cc)
  );

  // Longitude term, with the latitude term delayed alongside.
  logic signed [XW-1:0] lon_term;
  logic                 m2_vld;
  logic signed [XW-1:0] slat2_d_r [3];

  gcd_mul #(.AW(XW), .BW(XW), .SH(F), .OW(XW)) u_mul_lon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m1_vld),
    .a(cc), .b(slon2), .out_vld(m2_vld), .p(lon_term)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      slat2_d_r[0] <= slat2;
      slat2_d_r[1] <= slat2_d_r[0];
      slat2_d_r[2] <= slat2_d_r[1];
    end
  end

  // h, clamped to [0, 1], and its complement.
  logic signed [XW:0] h_sum;
  logic [HW-1:0]      h_r, hc_r;
  logic               h_vld_r;

  assign h_sum = (XW+1)'(slat2_d_r[2]) + (XW+1)'(lon_term);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (h_sum < 0) begin
        h_r  <= '0;
        hc_r <= ONE_H;
      end else if (h_sum > (XW+1)'(ONE_H)) begin
        h_r  <= ONE_H;
        hc_r <= '0;
      end else begin
        h_r  <= HW'(h_sum);
        hc_r <= ONE_H - HW'(h_sum);
      end
    end
  end

  // Square roots of h and 1 - h.
  logic [HW-1:0] root_y, root_x;
  logic          sq_vld;

  gcd_sqrt #(.F(F)) u_sqrt_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(h_vld_r),
    .v(h_r), .out_vld(sq_vld), .root(root_y)
  );

  gcd_sqrt #(.F(F)) u_sqrt_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(h_vld_r),
    .v(hc_r), .out_vld(), .root(root_x)
  );

  // Half the central angle by vectoring CORDIC; zero roots ride along as flags.
  logic signed [AW-1:0] vz;
  logic [1:0]           vflag;
  logic                 vec_vld;

  gcd_cordic #(
    .STAGES(CORDIC_STAGES), .F(F), .XW(XW), .ZW(AW), .SBW(2), .VECTOR(1'b1)
  ) u_vec (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sq_vld),
    .x0(XW'(root_x)), .y0(XW'(root_y)), .z0('0),
    .sb0({root_x == '0, root_y == '0}),
    .out_vld(vec_vld), .x(), .y(), .z(vz), .sb(vflag)
  );

  // Angle to [0, pi/2], with the zero-root cases.
  logic [HW-1:0] zc_r;
  logic          zc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zc_vld_r <= 1'b0;
    end else if (en) begin
      zc_vld_r <= vec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vflag[0]) begin
        zc_r <= '0;
      end else if (vflag[1]) begin
        zc_r <= HP_H;
      end else if (vz < 0) begin
        zc_r <= '0;
      end else if (vz > HP_A) begin
        zc_r <= HP_H;
      end else begin
        zc_r <= HW'(vz);
      end
    end
  end

  // Distance is the angle times twice the radius.
  logic signed [DW-1:0] dist_full;
  logic                 dist_vld;

  gcd_mul #(.AW(HW+1), .BW(32), .SH(F), .OW(DW)) u_mul_dist (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(zc_vld_r),
    .a(signed'({1'b0, zc_r})), .b(TWO_RADIUS_CM), .out_vld(dist_vld), .p(dist_full)
  );

  // Output register with saturation.
  logic [DIST_W-1:0] out_dist_r;
  logic              out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dist_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (unsigned'(dist_full) > DIST_MAX) begin
        out_dist_r <= DIST_W'(DIST_MAX);
      end else begin
        out_dist_r <= DIST_W'(dist_full);
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-DIST_W){1'b0}}, out_dist_r};

endmodule

`default_nettype wire
